// ===== sv/image_gradient_central_difference_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the central-difference gradient block
// Each macro expects clk and rst in scope; rst masks the check while high.
// ----------------------------------------------------------------------------
`ifndef IMAGE_GRADIENT_CENTRAL_DIFFERENCE_MACROS_SVH
`define IMAGE_GRADIENT_CENTRAL_DIFFERENCE_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property at every rising edge outside reset.
`define IGCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define IGCD_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define IGCD_ASSERT(label, prop, msg)
`define IGCD_NEVER(label, expr, msg)
`endif
`endif

// ===== sv/igcd_pkg.sv =====
// ----------------------------------------------------------------------------
// igcd_pkg
// Shared types, register indexes and the difference helper of the gradient.
// ----------------------------------------------------------------------------
`default_nettype none

package igcd_pkg;

  localparam int PIX_W        = 8;
  localparam int DIFF_W       = 9;
  localparam int GRAD_W       = 10;
  localparam int WIDTH_CFG_W  = 12;
  localparam int HEIGHT_CFG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 2;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Results a job can carry, in issue order.
  localparam int NUM_RES        = 4;
  localparam int RES_ABOVE_PREV = 0;  // row above, column c-1
  localparam int RES_ABOVE_LAST = 1;  // row above, last column
  localparam int RES_LAST_PREV  = 2;  // bottom row, column c-1
  localparam int RES_LAST_LAST  = 3;  // bottom row, last column

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic signed [GRAD_W-1:0] grad_t;

  // Pixel neighborhood around column c of the current row r.
  //   up_*  : row r-1 at columns c, c-1, c-2
  //   up2_* : row r-2 at columns c, c-1
  //   cur_* : row r at columns c, c-1, c-2
  typedef struct packed {
    pix_t                up_0;
    pix_t                up_1;
    pix_t                up_2;
    pix_t                up2_0;
    pix_t                up2_1;
    pix_t                cur_0;
    pix_t                cur_1;
    pix_t                cur_2;
    logic                first_col;  // column c-1 is column 0
    logic                top_pair;   // row r-1 is row 0
    logic [NUM_RES-1:0]  mask;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  // hi - lo, optionally doubled, as a gradient with one fraction bit.
  function automatic grad_t grad_of(pix_t hi, pix_t lo, logic dbl);
    logic signed [DIFF_W-1:0] d;
    d = $signed({1'b0, hi}) - $signed({1'b0, lo});
    return dbl ? {d, 1'b0} : {d[DIFF_W-1], d};
  endfunction

endpackage

`default_nettype wire

// ===== sv/image_gradient_central_difference.sv =====
// ----------------------------------------------------------------------------
// image_gradient_central_difference
// Central-difference gradient of a raster pixel stream, one fraction bit.
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   -------   ---------------------   ------------------------------------------
//   cfg       cfg_valid / cfg_ready   cfg_index, cfg_data (0 width, 1 height)
//   pixel     pix_valid / pix_ready   pixel
//   result    res_valid / res_ready   grad_x, grad_y, out_col, out_row, frame_end
//
// One pixel per cycle is taken while the job queue has room; the result for
// pixel (r-1, k) passes the s1 register, the job queue and the output register
// after pixel (r, k+1) is taken. The back issues one result per cycle while
// the result side accepts, so the row end (two results) and the bottom row
// (two results per pixel) set the intake's pace once the four-entry job queue is full.
// Reset clears the position, the queue and the output valid flag; no clearing
// pass is run, the line stores are read only where the current frame wrote.
// A stall on the result side holds the back and then the queue; the front
// keeps taking pixels until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module image_gradient_central_difference #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [igcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [igcd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              pix_valid,
  output logic                              pix_ready,
  input  igcd_pkg::pix_t                    pixel,
  output logic                              res_valid,
  input  logic                              res_ready,
  output igcd_pkg::grad_t                   grad_x,
  output igcd_pkg::grad_t                   grad_y,
  output logic [$clog2(MAX_WIDTH)-1:0]      out_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]     out_row,
  output logic                              frame_end
);
  import igcd_pkg::*;

  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int QDATA_W     = COL_W + ROW_W + JOB_W;
  localparam int QUEUE_DEPTH = 4;

  // Front to queue.
  logic               job_valid;
  logic               job_ready;
  job_t               job;
  logic [COL_W-1:0]   job_col;
  logic [ROW_W-1:0]   job_row;

  // Queue to back.
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  logic [QDATA_W-1:0] q_wdata;
  logic [QDATA_W-1:0] q_rdata;
  job_t               q_job;
  logic [COL_W-1:0]   q_col;
  logic [ROW_W-1:0]   q_row;

  // Front: count position, read the line stores, classify each pixel.
  igcd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COL_W      (COL_W),
    .ROW_W      (ROW_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pixel     (pixel),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .job_col   (job_col),
    .job_row   (job_row)
  );

  // Pack the job with its coordinates; hold it back while the queue is full.
  assign job_ready = !q_full;
  assign q_wdata   = {job_col, job_row, job};

  igcd_queue #(
    .DATA_W (QDATA_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid && job_ready),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_valid)
  );

  assign q_job = job_t'(q_rdata[JOB_W-1:0]);
  assign q_row = q_rdata[JOB_W +: ROW_W];
  assign q_col = q_rdata[JOB_W + ROW_W +: COL_W];

  // Back: one result per cycle into the output register while the result side accepts.
  igcd_back #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_job     (q_job),
    .q_col     (q_col),
    .q_row     (q_row),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .grad_x    (grad_x),
    .grad_y    (grad_y),
    .out_col   (out_col),
    .out_row   (out_row),
    .frame_end (frame_end)
  );

endmodule

`default_nettype wire

// ===== sv/igcd_front.sv =====
// ----------------------------------------------------------------------------
// igcd_front
// Accept pixels, keep the line stores and the pixel window, build jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module igcd_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int COL_W      = $clog2(MAX_WIDTH),
  parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [igcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [igcd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               pix_valid,
  output logic                               pix_ready,
  input  igcd_pkg::pix_t                     pixel,
  output logic                               job_valid,
  input  logic                               job_ready,
  output igcd_pkg::job_t                     job,
  output logic [COL_W-1:0]                   job_col,
  output logic [ROW_W-1:0]                   job_row
);
  import igcd_pkg::*;

  localparam int LAST_COL_RESET = (WIDTH_RESET > MAX_WIDTH ? MAX_WIDTH : WIDTH_RESET) - 1;
  localparam int LAST_ROW_RESET = (HEIGHT_RESET > MAX_HEIGHT ? MAX_HEIGHT : HEIGHT_RESET) - 1;

  logic [COL_W-1:0]        last_col;
  logic [ROW_W-1:0]        last_row;
  logic [COL_W-1:0]        width_last;
  logic [ROW_W-1:0]        height_last;
  logic [WIDTH_CFG_W-1:0]  wr_width;
  logic [HEIGHT_CFG_W-1:0] wr_height;

  logic [COL_W-1:0]        col;
  logic [ROW_W-1:0]        row;
  logic                    accept;

  pix_t                    line_up  [MAX_WIDTH];
  pix_t                    line_up2 [MAX_WIDTH];
  pix_t                    rd_up;
  pix_t                    rd_up2;

  logic                    s1_valid;
  pix_t                    s1_pix;
  logic [COL_W-1:0]        s1_col;
  logic [ROW_W-1:0]        s1_row;
  logic                    s1_row_end;
  logic                    s1_last_row;
  logic                    s1_col0;
  logic                    s1_col1;
  logic                    s1_row0;
  logic                    s1_row1;
  logic                    s1_fire;
  logic [NUM_RES-1:0]      mask;

  pix_t                    win_up_1;
  pix_t                    win_up_2;
  pix_t                    win_up2_1;
  pix_t                    win_cur_1;
  pix_t                    win_cur_2;

  // Configuration: store the clamped last column and last row.
  assign cfg_ready = 1'b1;
  assign wr_width  = cfg_data[WIDTH_CFG_W-1:0];
  assign wr_height = cfg_data[HEIGHT_CFG_W-1:0];

  always_comb begin
    if (wr_width < WIDTH_CFG_W'(2)) begin
      width_last = COL_W'(1);
    end else if (32'(wr_width) > MAX_WIDTH) begin
      width_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_last = COL_W'(wr_width - 1'b1);
    end
    if (wr_height < HEIGHT_CFG_W'(2)) begin
      height_last = ROW_W'(1);
    end else if (32'(wr_height) > MAX_HEIGHT) begin
      height_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      height_last = ROW_W'(wr_height - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= COL_W'(LAST_COL_RESET);
      last_row <= ROW_W'(LAST_ROW_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  last_col <= width_last;
        CFG_FRAME_HEIGHT: last_row <= height_last;
        default: ;
      endcase
    end
  end

  // Intake and raster position.
  assign pix_ready = !s1_valid || s1_fire;
  assign accept    = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == last_col) begin
        col <= '0;
        row <= (row == last_row) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Line stores: line_up holds the row above, line_up2 the row before that.
  always_ff @(posedge clk) begin
    if (accept) begin
      line_up[col] <= pixel;
      rd_up        <= line_up[col];
      rd_up2       <= line_up2[col];
    end
    if (s1_fire) begin
      line_up2[s1_col] <= rd_up;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_ready) begin
      s1_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix      <= pixel;
      s1_col      <= col;
      s1_row      <= row;
      s1_row_end  <= (col == last_col);
      s1_last_row <= (row == last_row);
      s1_col0     <= (col == '0);
      s1_col1     <= (col == COL_W'(1));
      s1_row0     <= (row == '0);
      s1_row1     <= (row == ROW_W'(1));
    end
  end

  // Classify: which results this pixel completes.
  always_comb begin
    mask                 = '0;
    mask[RES_ABOVE_PREV] = !s1_row0 && !s1_col0;
    mask[RES_ABOVE_LAST] = !s1_row0 && !s1_col0 && s1_row_end;
    mask[RES_LAST_PREV]  = s1_last_row && !s1_col0;
    mask[RES_LAST_LAST]  = s1_last_row && !s1_col0 && s1_row_end;
  end

  assign job_valid = s1_valid && (mask != '0);
  assign s1_fire   = s1_valid && ((mask == '0) || job_ready);

  always_comb begin
    job.up_0      = rd_up;
    job.up_1      = win_up_1;
    job.up_2      = win_up_2;
    job.up2_0     = rd_up2;
    job.up2_1     = win_up2_1;
    job.cur_0     = s1_pix;
    job.cur_1     = win_cur_1;
    job.cur_2     = win_cur_2;
    job.first_col = s1_col1;
    job.top_pair  = s1_row1;
    job.mask      = mask;
  end

  assign job_col = s1_col;
  assign job_row = s1_row;

  // Shift the window one column as each pixel leaves.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      win_up_2  <= win_up_1;
      win_up_1  <= rd_up;
      win_up2_1 <= rd_up2;
      win_cur_2 <= win_cur_1;
      win_cur_1 <= s1_pix;
    end
  end

endmodule

`default_nettype wire

// ===== sv/igcd_queue.sv =====
// ----------------------------------------------------------------------------
// igcd_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "image_gradient_central_difference_macros.svh"

module igcd_queue #(
  parameter int DATA_W = 1,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              not_empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `IGCD_NEVER(a_push_full, push && full, "job pushed into a full queue")
  `IGCD_NEVER(a_pop_empty, pop && !not_empty, "job popped from an empty queue")
  `IGCD_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "queue count past depth")
  `IGCD_ASSERT(a_empty_ptrs, !not_empty |-> (wr_ptr == rd_ptr), "empty queue, pointers apart")

endmodule

`default_nettype wire

// ===== sv/igcd_back.sv =====
// ----------------------------------------------------------------------------
// igcd_back
// Expand each job into its results, one per cycle while the result side accepts, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "image_gradient_central_difference_macros.svh"

module igcd_back #(
  parameter int COL_W = 11,
  parameter int ROW_W = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  igcd_pkg::job_t     q_job,
  input  logic [COL_W-1:0]   q_col,
  input  logic [ROW_W-1:0]   q_row,
  output logic               res_valid,
  input  logic               res_ready,
  output igcd_pkg::grad_t    grad_x,
  output igcd_pkg::grad_t    grad_y,
  output logic [COL_W-1:0]   out_col,
  output logic [ROW_W-1:0]   out_row,
  output logic               frame_end
);
  import igcd_pkg::*;

  logic [NUM_RES-1:0] done;
  logic [NUM_RES-1:0] pending;
  logic [NUM_RES-1:0] sel;
  logic               last_one;
  logic               issue;
  logic               above;
  logic               second;
  pix_t               x0;
  pix_t               x1;
  pix_t               x2;
  pix_t               hc;
  pix_t               ha;
  pix_t               hb;
  grad_t              gx;
  grad_t              gy;
  logic [COL_W-1:0]   col_sel;
  logic [ROW_W-1:0]   row_sel;

  // Take the lowest result not yet issued.
  assign pending  = q_job.mask & ~done;
  assign sel      = pending & (~pending + 1'b1);
  assign last_one = ((pending & ~sel) == '0);
  assign issue    = q_valid && (!res_valid || res_ready);
  assign q_pop    = issue && last_one;
  assign above    = sel[RES_ABOVE_PREV] || sel[RES_ABOVE_LAST];
  assign second   = sel[RES_ABOVE_LAST] || sel[RES_LAST_LAST];

  always_comb begin
    if (above) begin
      x0 = q_job.up_0;
      x1 = q_job.up_1;
      x2 = q_job.up_2;
    end else begin
      x0 = q_job.cur_0;
      x1 = q_job.cur_1;
      x2 = q_job.cur_2;
    end
    if (second) begin
      hc = q_job.cur_0;
      ha = q_job.up_0;
      hb = q_job.up2_0;
    end else begin
      hc = q_job.cur_1;
      ha = q_job.up_1;
      hb = q_job.up2_1;
    end
    // One-sided at the first and last column, central elsewhere.
    if (second || q_job.first_col) begin
      gx = grad_of(x0, x1, 1'b1);
    end else begin
      gx = grad_of(x0, x2, 1'b0);
    end
    // One-sided at the top and bottom row, central elsewhere.
    if (above && !q_job.top_pair) begin
      gy = grad_of(hc, hb, 1'b0);
    end else begin
      gy = grad_of(hc, ha, 1'b1);
    end
    col_sel = second ? q_col : q_col - 1'b1;
    row_sel = above ? q_row - 1'b1 : q_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (issue) begin
      done <= last_one ? '0 : (done | sel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (issue) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      grad_x    <= gx;
      grad_y    <= gy;
      out_col   <= col_sel;
      out_row   <= row_sel;
      frame_end <= sel[RES_LAST_LAST];
    end
  end

  `IGCD_ASSERT(a_sel_onehot, q_valid |-> $onehot(sel), "no single result selected")
  `IGCD_ASSERT(a_pop_last, q_pop |-> $onehot(pending), "job popped with results left")
  `IGCD_NEVER(a_done_orphan, !q_valid && (done != '0), "issue marks without a job")
  `IGCD_ASSERT(a_job_nonempty, q_valid |-> (q_job.mask != '0), "job without results")

endmodule

`default_nettype wire
